[rtl/utf8_pkg.sv]
package utf8_pkg;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_STOPPED   = 2'd1,
        ST_TRUNCATED = 2'd2
    } t_status;

    localparam int unsigned CP_W  = 31;
    localparam int unsigned REM_W = 3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_beat;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            has_code_point;
        logic            end_of_text;
        t_status         status;
    } t_out_beat;

endpackage

[rtl/utf8_byte_stream_decoder_top.sv]
// UTF-8 decoder for the original six-byte form: one byte per beat in, and
// at most one result per byte out, carrying a code point of up to 31 bits
// or, on the last byte of a text, an end mark with status ok, stopped or
// truncated. Each byte is first held in an input register; from there it
// is decoded against the sequence state and the result is written to an
// output register. It sustains one byte per cycle while i_ready is high;
// o_valid rises only for bytes that yield a result. Output backpressure
// reaches o_ready in the same cycle when both registers are occupied.
module utf8_byte_stream_decoder_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  utf8_pkg::t_in_beat   i_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output utf8_pkg::t_out_beat  o_data
);

    logic                                   r_in_valid;
    utf8_pkg::t_in_beat                     r_in;
    logic                                   r_out_valid;
    utf8_pkg::t_out_beat                    r_out;
    logic [utf8_pkg::CP_W-1:0]              r_partial;
    logic [utf8_pkg::REM_W-1:0]             r_remaining;
    logic                                   r_halted;

    logic [utf8_pkg::CP_W-1:0]              n_partial;
    logic [utf8_pkg::REM_W-1:0]             n_remaining;
    logic                                   n_halted;
    logic                                   n_emit;
    utf8_pkg::t_out_beat                    n_out;

    logic                                   advance;
    logic                                   done;
    logic [utf8_pkg::CP_W-1:0]              cp;
    logic [7:0]                             b;

    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;
    assign b       = r_in.data_byte;

    always_comb begin
        n_partial   = r_partial;
        n_remaining = r_remaining;
        n_halted    = r_halted;
        done        = 1'b0;
        cp          = '0;
        n_emit      = 1'b0;
        n_out       = '{code_point: '0, has_code_point: 1'b0,
                        end_of_text: 1'b0, status: utf8_pkg::ST_OK};

        if (!r_halted) begin
            priority if (r_remaining != '0) begin
                n_partial   = {r_partial[utf8_pkg::CP_W-7:0], b[5:0]};
                n_remaining = r_remaining - 3'd1;
                if (r_remaining == 3'd1) begin
                    done = 1'b1;
                    cp   = {r_partial[utf8_pkg::CP_W-7:0], b[5:0]};
                end
            end else if (!b[7]) begin
                done = 1'b1;
                cp   = {24'd0, b[6:0]};
            end else if (b[7:5] == 3'b110) begin
                n_partial   = {26'd0, b[4:0]};
                n_remaining = 3'd1;
            end else if (b[7:4] == 4'b1110) begin
                n_partial   = {27'd0, b[3:0]};
                n_remaining = 3'd2;
            end else if (b[7:3] == 5'b11110) begin
                n_partial   = {28'd0, b[2:0]};
                n_remaining = 3'd3;
            end else if (b[7:2] == 6'b111110) begin
                n_partial   = {29'd0, b[1:0]};
                n_remaining = 3'd4;
            end else if (b[7:1] == 7'b1111110) begin
                n_partial   = {30'd0, b[0]};
                n_remaining = 3'd5;
            end else begin
                n_halted = 1'b1;
            end
        end

        if (r_in.last_byte) begin
            n_emit            = 1'b1;
            n_out.end_of_text = 1'b1;
            priority if (n_halted) begin
                n_out.status = utf8_pkg::ST_STOPPED;
            end else if (done) begin
                n_out.code_point     = cp;
                n_out.has_code_point = 1'b1;
            end else begin
                n_out.status = utf8_pkg::ST_TRUNCATED;
            end
            n_partial   = '0;
            n_remaining = '0;
            n_halted    = 1'b0;
        end else if (done) begin
            n_emit               = 1'b1;
            n_out.code_point     = cp;
            n_out.has_code_point = 1'b1;
            n_partial            = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_partial   <= '0;
            r_remaining <= '0;
            r_halted    <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end

            if (advance) begin
                r_out_valid <= n_emit;
                r_partial   <= n_partial;
                r_remaining <= n_remaining;
                r_halted    <= n_halted;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in <= i_data;
        end
        if (advance && n_emit) begin
            r_out <= n_out;
        end
    end

    a_eot_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in.last_byte |=> r_remaining == '0 && !r_halted)
        else $error("state not cleared after last byte");

    a_status_eot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.status != utf8_pkg::ST_OK |-> r_out.end_of_text)
        else $error("non-ok status without end of text");

    a_empty_eot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.has_code_point |-> r_out.end_of_text)
        else $error("result without code point before end of text");

    a_halt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |-> r_remaining == '0)
        else $error("halted inside a sequence");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid && $stable(r_in))
        else $error("input register lost a beat");

endmodule
